[rtl/core/bubble_sort_words_unit_macros.svh]
// Assertion macros for the bubble sort words unit.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BUBBLE_SORT_WORDS_UNIT_MACROS_SVH
`define BUBBLE_SORT_WORDS_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define BSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define BSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bsw_pkg.sv]
// Shared types and constants for the bubble sort words unit.
// No dependencies.
package bsw_pkg;

  localparam int WordW = 64;

  typedef struct packed {
    logic [WordW-1:0] word_value;
    logic             last_word;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] sorted_word;
    logic             last_out;
    logic             overflow;
  } out_item_t;

endpackage

[rtl/core/bubble_sort_words_unit.sv]
// Load: one item per cycle while idle; a word is written to the store in that cycle unless the store is full.
// Sort: after the last item of a set of two or more words, passes repeat until a pass
// makes no swap (at most n passes, n = stored words); each compare step reads one store entry and writes one back.
// Output: a read state, then one result item per cycle unless out_stall holds it.
// Reset clears the count, flags and handshake state; store contents stay undefined.
// No new item is taken from the last item of a set until its final result is loaded.
`include "bubble_sort_words_unit_macros.svh"

module bubble_sort_words_unit
  import bsw_pkg::*;
#(
  parameter int MAX_WORDS      = 64,
  parameter int CHARS_PER_WORD = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW   = $clog2(MAX_WORDS);
  localparam int CNTW = $clog2(MAX_WORDS + 1);
  localparam logic [WordW-1:0] CharMask = {WordW{1'b1}} << (8 * (8 - CHARS_PER_WORD));

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [WordW-1:0] mem [MAX_WORDS];
  logic [WordW-1:0] rdata_r;

  logic [2:0]       state_r, state_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             swap_r, swap_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [WordW-1:0] carry_r, carry_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [WordW-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [CNTW-1:0]  cnt_m1;
  logic [AW-1:0]    last_idx;
  logic             gt;
  logic             out_load;

  assign cnt_m1   = count_r - CNTW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign gt       = carry_r > rdata_r;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    swap_nxt      = swap_r;
    idx_nxt       = idx_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (count_r < CNTW'(MAX_WORDS)) begin
            wr_en     = 1'b1;
            wr_addr   = count_r[AW-1:0];
            wr_data   = in_data.word_value & CharMask;
            count_nxt = count_r + CNTW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_data.last_word) begin
            idx_nxt   = '0;
            state_nxt = (count_nxt > CNTW'(1)) ? S_START : S_ORD;
          end
        end
      end
      S_START: begin
        rd_addr   = '0;
        swap_nxt  = 1'b0;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // entry 0 becomes the bubble carried along the pass
        carry_nxt = rdata_r;
        idx_nxt   = AW'(1);
        rd_addr   = AW'(1);
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // carry holds the largest seen so far; the smaller goes back at idx-1
        rd_addr   = idx_r + AW'(1);
        wr_en     = 1'b1;
        wr_addr   = idx_r - AW'(1);
        wr_data   = gt ? rdata_r : carry_r;
        carry_nxt = gt ? carry_r : rdata_r;
        if (gt) begin
          swap_nxt = 1'b1;
        end
        if (idx_r == last_idx) begin
          state_nxt = S_END;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_END: begin
        wr_en   = 1'b1;
        wr_addr = last_idx;
        wr_data = carry_r;
        if (swap_r) begin
          rd_addr   = '0;
          swap_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_ORD;
        end
      end
      S_ORD: begin
        rd_addr   = idx_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        rd_addr = idx_r;
        if (out_load) begin
          out_valid_nxt       = 1'b1;
          out_nxt.sorted_word = rdata_r;
          out_nxt.last_out    = (idx_r == last_idx);
          out_nxt.overflow    = dropped_r;
          if (idx_r == last_idx) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_addr = idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      swap_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      swap_r      <= swap_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    out_r   <= out_nxt;
  end

  `BSW_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNTW'(MAX_WORDS), "word count past store depth")
  `BSW_ASSERT_NOW(a_drop_full, dropped_r, count_r == CNTW'(MAX_WORDS), "drop flagged with room left")
  `BSW_ASSERT_NOW(a_pass_clean, state_r == S_LOAD, !swap_r, "pass started with swap flag set")
  `BSW_ASSERT_NEXT(a_set_done, out_load && out_nxt.last_out, state_r == S_IDLE && count_r == '0,
                   "set not closed after final item")

endmodule

[test/bubble_sort_words_unit_test.sv]
`timescale 1ns / 1ps
// Testbench for bubble_sort_words_unit: sends sets of words and checks the sorted stream.
// Depends on bsw_pkg and the unit itself; nothing else.
module bubble_sort_words_unit_test;
  import bsw_pkg::*;

  localparam int MaxWords = 64;
  localparam int CharsPerWord = 8;
  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 20;
  localparam int TotalItems = 420;

  typedef logic [WordW-1:0] word_t;
  typedef enum int {StallNone, StallRandom, StallPattern} stall_mode_t;

  // byte lanes past CharsPerWord characters are cleared before a word is stored
  localparam word_t CharMask = {WordW{1'b1}} << (8 * ((8 - CharsPerWord) % 8));

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // predictor state
  word_t held_words[MaxWords];
  int unsigned held_count = 0;
  bit held_dropped = 1'b0;
  out_item_t sorted_words_due[$];

  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_count = 0;
  bit sender_bursty = 1'b0;
  int unsigned burst_left = 0;
  stall_mode_t stall_mode = StallNone;
  logic [7:0] stall_pattern = 8'b0010_0110;
  bit hold_armed = 1'b0;
  int unsigned hold_left = 0;
  word_t prev_word = '0;
  out_item_t due_word;

  bubble_sort_words_unit #(
    .MAX_WORDS(MaxWords),
    .CHARS_PER_WORD(CharsPerWord)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Stores one word; on the last word of a set, sorts the set and queues its results.
  function automatic void load_and_sort_word(input in_item_t item);
    word_t w;
    word_t tmp;
    bit swapped;
    int unsigned i;
    int unsigned k;
    out_item_t res;
    w = item.word_value & CharMask;
    if (held_count < MaxWords) begin
      held_words[held_count] = w;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (item.last_word) begin
      do begin
        swapped = 1'b0;
        for (i = 0; i + 1 < held_count; i++) begin
          if (held_words[i] > held_words[i + 1]) begin
            tmp = held_words[i];
            held_words[i] = held_words[i + 1];
            held_words[i + 1] = tmp;
            swapped = 1'b1;
          end
        end
      end while (swapped);
      for (k = 0; k < held_count; k++) begin
        res.sorted_word = held_words[k];
        res.last_out = (k + 1 == held_count);
        res.overflow = held_dropped;
        sorted_words_due.push_back(res);
      end
      held_count = 0;
      held_dropped = 1'b0;
    end
  endfunction

  function automatic word_t random_word();
    word_t w;
    int unsigned len;
    int unsigned k;
    w = '0;
    case ($urandom_range(0, 5))
      0, 1: w = {$urandom, $urandom};
      2, 3: begin
        // lowercase text, zero padded
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) w[WordW - 1 - 8 * k -: 8] = 8'($urandom_range(97, 122));
      end
      4: w = prev_word;
      default: begin
        case ($urandom_range(0, 3))
          0: w = '0;
          1: w = '1;
          2: w = word_t'(1) << $urandom_range(0, WordW - 1);
          default: w = ~(word_t'(1) << $urandom_range(0, WordW - 1));
        endcase
      end
    endcase
    prev_word = w;
    return w;
  endfunction

  // Called and returns at a falling edge; valid stays high for a following item.
  task automatic send_word(input word_t word, input logic last);
    in_item_t item;
    item.word_value = word;
    item.last_word = last;
    if (sender_bursty && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_data = item;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    load_and_sort_word(item);
    items_sent++;
    if (burst_left != 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic test_directed_sets();
    sender_bursty = 1'b0;
    stall_mode = StallNone;
    send_word({"pear", 32'd0}, 1'b0);
    send_word({"apple", 24'd0}, 1'b0);
    send_word({"fig", 40'd0}, 1'b1);
    // one-word set
    send_word('1, 1'b1);
    stall_mode = StallRandom;
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word(word_t'(1), 1'b1);
    // a prefix sorts ahead of the longer word
    send_word({"apples", 16'd0}, 1'b0);
    send_word({"app", 40'd0}, 1'b0);
    send_word({"apple", 24'd0}, 1'b0);
    send_word({"b", 56'd0}, 1'b1);
    sender_bursty = 1'b1;
    send_word({"zz", 48'd0}, 1'b0);
    send_word({"zz", 48'd0}, 1'b0);
    send_word({"zz", 48'd0}, 1'b1);
  endtask

  task automatic test_store_full();
    int unsigned k;
    sender_bursty = 1'b0;
    stall_mode = StallPattern;
    // exactly full, reverse order for the longest sort
    for (k = 0; k < MaxWords; k++) begin
      send_word({8'(MaxWords - k), 24'($urandom), $urandom}, k == MaxWords - 1);
    end
    // two words too many; the dropped last word still starts the sort
    sender_bursty = 1'b1;
    stall_mode = StallRandom;
    for (k = 0; k < MaxWords + 2; k++) send_word(random_word(), k == MaxWords + 1);
  endtask

  task automatic test_output_backpressure();
    int unsigned k;
    sender_bursty = 1'b0;
    stall_mode = StallNone;
    hold_armed = 1'b1;
    for (k = 0; k < 24; k++) send_word(random_word(), k == 23);
    // offered while the previous set is held at the output
    for (k = 0; k < 10; k++) send_word(random_word(), k == 9);
  endtask

  task automatic test_random_sets();
    int unsigned set_len;
    int unsigned k;
    while (items_sent < TotalItems) begin
      case ($urandom_range(0, 19))
        0: set_len = $urandom_range(MaxWords - 1, MaxWords + 4);
        1, 2: set_len = $urandom_range(11, 40);
        3, 4: set_len = 1;
        default: set_len = $urandom_range(2, 10);
      endcase
      sender_bursty = ($urandom_range(0, 2) != 0);
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_pattern = 8'($urandom);
      for (k = 0; k < set_len; k++) send_word(random_word(), k + 1 == set_len);
    end
  endtask

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  // receiver: own stall pattern, plus one long hold once results start coming
  always @(negedge clk) begin
    if (hold_armed && out_valid) begin
      hold_left = HoldCycles;
      hold_armed = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        StallNone: out_stall = 1'b0;
        StallRandom: out_stall = ($urandom_range(0, 2) == 0);
        default: begin
          out_stall = stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_words_due.size() == 0) begin
        note_failure($sformatf("unexpected item word=%h last=%b ovf=%b",
                               out_data.sorted_word, out_data.last_out, out_data.overflow));
      end else begin
        due_word = sorted_words_due.pop_front();
        if (out_data.sorted_word !== due_word.sorted_word ||
            out_data.last_out !== due_word.last_out ||
            out_data.overflow !== due_word.overflow) begin
          note_failure($sformatf("exp word=%h last=%b ovf=%b, got word=%h last=%b ovf=%b",
                                 due_word.sorted_word, due_word.last_out, due_word.overflow,
                                 out_data.sorted_word, out_data.last_out, out_data.overflow));
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_sets();
    test_store_full();
    test_output_backpressure();
    test_random_sets();
    in_valid = 1'b0;
    while (sorted_words_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/bsw_pkg.sv
rtl/core/bubble_sort_words_unit.sv
test/bubble_sort_words_unit_test.sv
